// ===== rtl/round_robin_run_queue_macros.svh =====
// Assertion macros used by the run queue top level.
`ifndef ROUND_ROBIN_RUN_QUEUE_MACROS_SVH
`define ROUND_ROBIN_RUN_QUEUE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define RRQ_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("run queue check failed");

// Next-cycle implication, checked out of reset.
`define RRQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("run queue check failed");

`endif

// ===== rtl/rrq_pkg.sv =====
package rrq_pkg;

  localparam int MAX_TASKS = 64;
  localparam int TASK_W    = 6;
  localparam int SLICE_W   = 16;
  localparam int CNT_W     = 7;
  localparam int CMD_W     = 3;
  localparam int STAT_W    = 2;

  localparam logic [SLICE_W-1:0] SLICE_RESET = 16'd10;

  // command codes
  localparam logic [CMD_W-1:0] CMD_ENQ    = 3'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PICK   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_TICK   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_YIELD  = 3'd4;
  localparam logic [CMD_W-1:0] CMD_RELOAD = 3'd5;

  // result status codes
  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_QUEUED = 2'd1;
  localparam logic [STAT_W-1:0] ST_ABSENT = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

  typedef struct packed {
    logic [CMD_W-1:0]  cmd;
    logic [TASK_W-1:0] task_id;
    logic              task_is_rr;
  } in_item_t;

  typedef struct packed {
    logic              picked_valid;
    logic [TASK_W-1:0] picked_task;
    logic              need_resched;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  queue_count;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic rd_en;
    logic exec;
    logic append;
    logic load_out;
  } ctrl_t;

  // datapath -> controller
  typedef struct packed {
    logic go_append;
  } dp_stat_t;

endpackage

// ===== rtl/rrq_ctrl.sv =====
module rrq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  rrq_pkg::dp_stat_t stat,
  output rrq_pkg::ctrl_t    ctrl
);

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_READ   = 5'b00010,
    S_EXEC   = 5'b00100,
    S_APPEND = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    ctrl      = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.accept = 1'b1;
          state_nxt   = S_READ;
        end
      end
      S_READ: begin
        ctrl.rd_en = 1'b1;
        state_nxt  = S_EXEC;
      end
      S_EXEC: begin
        ctrl.exec = 1'b1;
        state_nxt = stat.go_append ? S_APPEND : S_DONE;
      end
      S_APPEND: begin
        ctrl.append = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        // wait for the output slot to drain
        if (!out_valid_r || !out_stall) begin
          ctrl.load_out = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (ctrl.load_out) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r & out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== rtl/rrq_datapath.sv =====
module rrq_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  rrq_pkg::ctrl_t               ctrl,
  output rrq_pkg::dp_stat_t            stat,
  input  rrq_pkg::in_item_t            in_data,
  output rrq_pkg::out_item_t           out_data,
  input  logic                         cfg_we,
  input  logic [rrq_pkg::SLICE_W-1:0]  cfg_data
);

  // link and slice stores, no reset
  logic [rrq_pkg::TASK_W-1:0]  next_mem  [rrq_pkg::MAX_TASKS];
  logic [rrq_pkg::TASK_W-1:0]  prev_mem  [rrq_pkg::MAX_TASKS];
  logic [rrq_pkg::SLICE_W-1:0] slice_mem [rrq_pkg::MAX_TASKS];

  logic [rrq_pkg::TASK_W-1:0]  rd_next_r, rd_prev_r;
  logic [rrq_pkg::SLICE_W-1:0] rd_slice_r;

  rrq_pkg::in_item_t  item_r;
  rrq_pkg::out_item_t out_r;

  logic [rrq_pkg::SLICE_W-1:0]   slice_ticks_r;
  logic [rrq_pkg::TASK_W-1:0]    head_r, head_nxt;
  logic [rrq_pkg::TASK_W-1:0]    tail_r, tail_nxt;
  logic [rrq_pkg::CNT_W-1:0]     count_r, count_nxt;
  logic [rrq_pkg::MAX_TASKS-1:0] mark_r, mark_nxt;

  logic                        pv_r, pv_nxt;
  logic [rrq_pkg::TASK_W-1:0]  pt_r, pt_nxt;
  logic                        nr_r, nr_nxt;
  logic [rrq_pkg::STAT_W-1:0]  st_r, st_nxt;

  logic                        next_we, prev_we, slice_we;
  logic [rrq_pkg::TASK_W-1:0]  next_wa, next_wd, prev_wa, prev_wd, slice_wa;
  logic [rrq_pkg::SLICE_W-1:0] slice_wd;

  logic [rrq_pkg::TASK_W-1:0] tid;
  logic                       marked;
  logic                       can_move;
  logic                       do_unlink;
  logic [rrq_pkg::CNT_W-1:0]  cnt_dec;

  assign tid      = item_r.task_id;
  assign marked   = mark_r[tid];
  // a queued task rotates only if it is not already last and not alone
  assign can_move = marked && (count_r > 7'd1) && (tail_r != tid);
  assign cnt_dec  = count_r - 7'd1;

  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    count_nxt      = count_r;
    mark_nxt       = mark_r;
    pv_nxt         = pv_r;
    pt_nxt         = pt_r;
    nr_nxt         = nr_r;
    st_nxt         = st_r;
    next_we        = 1'b0;
    next_wa        = '0;
    next_wd        = '0;
    prev_we        = 1'b0;
    prev_wa        = '0;
    prev_wd        = '0;
    slice_we       = 1'b0;
    slice_wa       = tid;
    slice_wd       = slice_ticks_r;
    do_unlink      = 1'b0;
    stat.go_append = 1'b0;

    if (ctrl.accept) begin
      pv_nxt = 1'b0;
      pt_nxt = '0;
      nr_nxt = 1'b0;
      st_nxt = rrq_pkg::ST_OK;
    end

    if (ctrl.exec) begin
      case (item_r.cmd)
        rrq_pkg::CMD_ENQ: begin
          if (marked) begin
            st_nxt = rrq_pkg::ST_QUEUED;
          end else begin
            slice_we       = 1'b1;
            stat.go_append = 1'b1;
          end
        end
        rrq_pkg::CMD_DEQ: begin
          if (marked) begin
            do_unlink = 1'b1;
          end else begin
            st_nxt = rrq_pkg::ST_ABSENT;
          end
        end
        rrq_pkg::CMD_PICK: begin
          if (count_r == '0) begin
            st_nxt = rrq_pkg::ST_EMPTY;
          end else begin
            pv_nxt = 1'b1;
            pt_nxt = head_r;
          end
        end
        rrq_pkg::CMD_TICK: begin
          if (item_r.task_is_rr) begin
            slice_we = 1'b1;
            if (rd_slice_r > 16'd1) begin
              slice_wd = rd_slice_r - 16'd1;
            end else begin
              // slice expired: reload and rotate
              nr_nxt         = 1'b1;
              do_unlink      = can_move;
              stat.go_append = can_move;
            end
          end
        end
        rrq_pkg::CMD_YIELD: begin
          if (!marked) begin
            st_nxt = rrq_pkg::ST_ABSENT;
          end else begin
            do_unlink      = can_move;
            stat.go_append = can_move;
          end
        end
        rrq_pkg::CMD_RELOAD: begin
          slice_we = 1'b1;
        end
        default: ;
      endcase

      if (do_unlink) begin
        if (head_r == tid) begin
          head_nxt = rd_next_r;
        end else begin
          next_we = 1'b1;
          next_wa = rd_prev_r;
          next_wd = rd_next_r;
        end
        if (tail_r == tid) begin
          tail_nxt = rd_prev_r;
        end else begin
          prev_we = 1'b1;
          prev_wa = rd_next_r;
          prev_wd = rd_prev_r;
        end
        mark_nxt[tid] = 1'b0;
        count_nxt     = cnt_dec;
        if (cnt_dec == '0) begin
          head_nxt = '0;
          tail_nxt = '0;
        end
      end
    end

    if (ctrl.append) begin
      if (count_r == '0) begin
        head_nxt = tid;
      end else begin
        next_we = 1'b1;
        next_wa = tail_r;
        next_wd = tid;
        prev_we = 1'b1;
        prev_wa = tid;
        prev_wd = tail_r;
      end
      tail_nxt      = tid;
      mark_nxt[tid] = 1'b1;
      count_nxt     = count_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[next_wa] <= next_wd;
    end
    if (ctrl.rd_en) begin
      rd_next_r <= next_mem[tid];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[prev_wa] <= prev_wd;
    end
    if (ctrl.rd_en) begin
      rd_prev_r <= prev_mem[tid];
    end
  end

  always_ff @(posedge clk) begin
    if (slice_we) begin
      slice_mem[slice_wa] <= slice_wd;
    end
    if (ctrl.rd_en) begin
      rd_slice_r <= slice_mem[tid];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slice_ticks_r <= rrq_pkg::SLICE_RESET;
      head_r        <= '0;
      tail_r        <= '0;
      count_r       <= '0;
      mark_r        <= '0;
    end else begin
      if (cfg_we) begin
        slice_ticks_r <= cfg_data;
      end
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
      mark_r  <= mark_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pv_r <= pv_nxt;
    pt_r <= pt_nxt;
    nr_r <= nr_nxt;
    st_r <= st_nxt;
    if (ctrl.accept) begin
      item_r <= in_data;
    end
    if (ctrl.load_out) begin
      out_r.picked_valid <= pv_r;
      out_r.picked_task  <= pt_r;
      out_r.need_resched <= nr_r;
      out_r.status       <= st_r;
      out_r.queue_count  <= count_r;
    end
  end

  assign out_data = out_r;

endmodule

// ===== rtl/round_robin_run_queue.sv =====
// Round-robin run queue: task ids 0..63 held in one FIFO built as a doubly
// linked list, with a 16-bit time slice per task. One command beat in, one
// result beat out. A command steps through IDLE, READ, EXEC and DONE; an
// enqueue that links in a new task, and a tick or yield that rotates the
// task to the tail, also pass through APPEND, as the link and slice memories
// are read through a register and take one write per link memory per cycle:
// unlinking and re-linking at the tail each need their own write cycle.
// A finished result waits in the output register while the next command is
// taken; that command then holds until the register drains. The link and
// slice memories are not cleared; in the datapath only the queued flags,
// head, tail, count and slice_ticks are reset: ready straight after reset.
// cfg_data sets slice_ticks and is always taken; write it only while idle.
`include "round_robin_run_queue_macros.svh"

module round_robin_run_queue (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  rrq_pkg::in_item_t           in_data,
  output logic                        out_valid,
  input  logic                        out_stall,
  output rrq_pkg::out_item_t          out_data,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [rrq_pkg::SLICE_W-1:0] cfg_data
);

  rrq_pkg::ctrl_t    ctrl;
  rrq_pkg::dp_stat_t stat;

  assign cfg_ready = 1'b1;

  rrq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .ctrl      (ctrl)
  );

  rrq_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctrl     (ctrl),
    .stat     (stat),
    .in_data  (in_data),
    .out_data (out_data),
    .cfg_we   (cfg_valid & cfg_ready),
    .cfg_data (cfg_data)
  );

  `RRQ_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)
  `RRQ_ASSERT_IMPL(a_count_range, out_valid, out_data.queue_count <= 7'd64)
  `RRQ_ASSERT_IMPL(a_pick_ok, out_valid && out_data.picked_valid, out_data.status == rrq_pkg::ST_OK)
  `RRQ_ASSERT_IMPL(a_resched_no_pick, out_valid && out_data.need_resched, !out_data.picked_valid)

endmodule
